// ===== design/iee_pkg.sv =====
// Package for the infix expression evaluator: widths, character codes,
// status codes and the token class type shared by front and back ends.
package iee_pkg;

    localparam int MAX_DEPTH_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int TOKQ_DEPTH      = 2;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TOKEN = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_DEEP  = 2'd3;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_OPEN,
        TK_CLOSE,
        TK_MUL,
        TK_ADD,
        TK_END,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] ch;
    } token_t;

endpackage

// ===== design/iee_front.sv =====
// Front end: accepts characters and classifies them into tokens.
// Depends on iee_pkg.
module iee_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    char_code,
    input  logic          push,
    output logic          full,
    output iee_pkg::token_t tok,
    output logic          tok_valid,
    input  logic          tok_ready
);
    import iee_pkg::*;

    token_t q_reg [TOKQ_DEPTH];
    logic   wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    token_t t_in;
    logic do_push, do_pop;

    always_comb
    begin
        t_in.ch = char_code;
        if (char_code == 8'd0)
            t_in.kind = TK_END;
        else if (char_code inside {[CH_ZERO:CH_NINE]})
            t_in.kind = TK_DIGIT;
        else if (char_code == CH_OPEN)
            t_in.kind = TK_OPEN;
        else if (char_code == CH_CLOSE)
            t_in.kind = TK_CLOSE;
        else if (char_code == CH_MUL)
            t_in.kind = TK_MUL;
        else if (char_code == CH_ADD)
            t_in.kind = TK_ADD;
        else
            t_in.kind = TK_OTHER;
    end

    assign full      = (cnt_reg == 2'(TOKQ_DEPTH));
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = tok_valid && tok_ready;
    assign wp_next   = do_push ? ~wp_reg : wp_reg;
    assign rp_next   = do_pop ? ~rp_reg : rp_reg;
    assign cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= t_in;
    end

endmodule

// ===== design/iee_back.sv =====
// Back end: executes tokens on the running sum/product and a frame stack,
// holds one result register. Depends on iee_pkg.
module iee_back #(
    parameter int MAX_DEPTH   = iee_pkg::MAX_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  iee_pkg::token_t tok,
    input  logic            tok_valid,
    output logic            tok_ready,
    output logic [31:0]     value,
    output logic [1:0]      status,
    output logic [7:0]      bad_char,
    output logic            empty,
    input  logic            pop
);
    import iee_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [VALUE_WIDTH-1:0] sum_reg, sum_next, prod_reg, prod_next;
    logic [VALUE_WIDTH-1:0] stk_sum [MAX_DEPTH];
    logic [VALUE_WIDTH-1:0] stk_prod [MAX_DEPTH];
    logic [LW-1:0] lvl_reg, lvl_next;
    logic       exp_reg, exp_next;
    logic [1:0] err_reg, err_next;
    logic [7:0] ech_reg, ech_next;
    logic       rv_reg, rv_next;
    logic [31:0] rval_reg, rval_next;
    logic [1:0]  rst_reg, rst_next;
    logic [7:0]  rch_reg, rch_next;
    logic [VALUE_WIDTH-1:0] inner, factor, top_sum, top_prod;
    logic [AW-1:0] push_idx, pop_idx;
    logic take, do_push_stk;

    // Only an end token needs the result register free.
    assign tok_ready = !rv_reg || pop || (tok.kind != TK_END);
    assign take      = tok_valid && tok_ready;
    assign empty     = !rv_reg;
    assign value     = rval_reg;
    assign status    = rst_reg;
    assign bad_char  = rch_reg;
    assign inner     = sum_reg + prod_reg;
    assign push_idx  = AW'(lvl_reg);
    assign pop_idx   = AW'(lvl_reg - LW'(1));
    assign top_sum   = stk_sum[pop_idx];
    assign top_prod  = stk_prod[pop_idx];

    always_comb
    begin
        sum_next  = sum_reg;
        prod_next = prod_reg;
        lvl_next  = lvl_reg;
        exp_next  = exp_reg;
        err_next  = err_reg;
        ech_next  = ech_reg;
        rv_next   = rv_reg && !pop;
        rval_next = rval_reg;
        rst_next  = rst_reg;
        rch_next  = rch_reg;
        factor    = '0;
        do_push_stk = 1'b0;
        if (take)
        begin
            if (tok.kind == TK_END)
            begin
                rv_next   = 1'b1;
                rval_next = '0;
                rst_next  = err_reg;
                rch_next  = (err_reg == ST_TOKEN) ? ech_reg : 8'd0;
                if (err_reg == ST_OK)
                begin
                    if (exp_reg || lvl_reg != '0)
                        rst_next = ST_END;
                    else
                        rval_next = 32'(inner);
                end
                sum_next  = '0;
                prod_next = VALUE_WIDTH'(1);
                lvl_next  = '0;
                exp_next  = 1'b1;
                err_next  = ST_OK;
                ech_next  = 8'd0;
            end
            else if (err_reg != ST_OK)
            begin
            end
            else if (exp_reg)
            begin
                case (tok.kind)
                    TK_DIGIT:
                    begin
                        factor    = VALUE_WIDTH'(tok.ch - CH_ZERO);
                        prod_next = prod_reg * factor;
                        exp_next  = 1'b0;
                    end
                    TK_OPEN:
                    begin
                        if (lvl_reg >= LW'(MAX_DEPTH))
                            err_next = ST_DEEP;
                        else
                        begin
                            do_push_stk = 1'b1;
                            lvl_next  = lvl_reg + LW'(1);
                            sum_next  = '0;
                            prod_next = VALUE_WIDTH'(1);
                        end
                    end
                    default:
                    begin
                        err_next = ST_TOKEN;
                        ech_next = tok.ch;
                    end
                endcase
            end
            else
            begin
                case (tok.kind)
                    TK_MUL:
                        exp_next = 1'b1;
                    TK_ADD:
                    begin
                        sum_next  = inner;
                        prod_next = VALUE_WIDTH'(1);
                        exp_next  = 1'b1;
                    end
                    TK_CLOSE:
                    begin
                        if (lvl_reg != '0)
                        begin
                            lvl_next  = lvl_reg - LW'(1);
                            sum_next  = top_sum;
                            prod_next = top_prod * inner;
                        end
                        else
                        begin
                            err_next = ST_TOKEN;
                            ech_next = tok.ch;
                        end
                    end
                    default:
                    begin
                        err_next = ST_TOKEN;
                        ech_next = tok.ch;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prod_reg <= VALUE_WIDTH'(1);
            lvl_reg  <= '0;
            exp_reg  <= 1'b1;
            err_reg  <= ST_OK;
            ech_reg  <= 8'd0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            prod_reg <= prod_next;
            lvl_reg  <= lvl_next;
            exp_reg  <= exp_next;
            err_reg  <= err_next;
            ech_reg  <= ech_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rval_reg <= rval_next;
        rst_reg  <= rst_next;
        rch_reg  <= rch_next;
        if (do_push_stk)
        begin
            stk_sum[push_idx]  <= sum_reg;
            stk_prod[push_idx] <= prod_reg;
        end
    end

endmodule

// ===== design/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator.
// Depends on iee_pkg, iee_front and iee_back.
//
// Usage:
//   Input queue side: drive char_code and raise push; a character is taken
//   on a clock edge with push high and full low. A zero byte ends the
//   expression.
//   Result queue side: while empty is low, value/status/bad_char hold the
//   result of the last finished expression; pop high takes it.
//   Flow: a character enters a two-entry token queue, from which the executor
//   consumes it; the result of a zero byte is registered on the ports when
//   the executor takes that byte.
//   Throughput: one character per cycle unless a zero byte meets an unpopped
//   result (at most one add, one multiply and a frame push or pop per token).
//   Reset: rst_n low clears the token queue, the result valid flag and the
//   evaluation state; result data and frame contents are not cleared.
//   Stall: while a result waits unpopped the executor still consumes
//   non-terminating characters; a further zero byte waits in the token
//   queue, and full rises once it fills.
module infix_expression_evaluator #(
    parameter int MAX_DEPTH   = iee_pkg::MAX_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  logic        push,
    output logic        full,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic [7:0]  bad_char,
    output logic        empty,
    input  logic        pop
);
    import iee_pkg::*;

    token_t tok;
    logic   tok_valid, tok_ready;

    iee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .push      (push),
        .full      (full),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready)
    );

    iee_back #(
        .MAX_DEPTH   (MAX_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .value     (value),
        .status    (status),
        .bad_char  (bad_char),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
